@@ hw/rtl/dstwr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dstwr_pkg
// Types, constants and the divider step shared by the time-of-flight core.
// ----------------------------------------------------------------------------
package dstwr_pkg;

    // Timestamp counter width; intervals wrap at this width.
    localparam int STAMP_BITS = 40;
    localparam int FIELD_W    = 40;
    localparam int DEN_W      = STAMP_BITS + 2;
    localparam int PROD_W     = 2 * STAMP_BITS;
    localparam int HALF_W     = (STAMP_BITS + 1) / 2;

    localparam int TOF_W      = 42;
    localparam int DIST_W     = 32;
    localparam int SCALE_W    = 40;
    localparam int MAXD_W     = 31;
    localparam int FRAC_W     = 16;

    // Divider: one quotient bit per flight-time bit, two bits per stage.
    localparam int QB         = TOF_W;
    localparam int DIV_STEPS  = 2;
    localparam int DIV_STAGES = QB / DIV_STEPS;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 40;
    localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_SCALE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DISTANCE_MM = CFG_IDX_W'(1);

    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(307475);
    localparam logic [MAXD_W-1:0]  MAXD_RESET  = MAXD_W'(100000);

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_ZERO_DEN  = 2'd1;
    localparam logic [1:0] ST_SATURATED = 2'd2;

    localparam logic [TOF_W-1:0] TOF_MAX_POS = {1'b0, {(TOF_W-1){1'b1}}};
    localparam logic [TOF_W-1:0] TOF_MAG_NEG = {1'b1, {(TOF_W-1){1'b0}}};

    typedef struct packed {
        logic [FIELD_W-1:0] poll_tx_time;
        logic [FIELD_W-1:0] poll_rx_time;
        logic [FIELD_W-1:0] resp_tx_time;
        logic [FIELD_W-1:0] resp_rx_time;
        logic [FIELD_W-1:0] final_tx_time;
        logic [FIELD_W-1:0] final_rx_time;
    } in_item_t;

    typedef struct packed {
        logic signed [TOF_W-1:0]  flight_time;
        logic signed [DIST_W-1:0] range_mm;
        logic [1:0]               status;
        logic                     out_of_range;
    } out_item_t;

    typedef struct packed {
        logic zero_den;
        logic neg;
        logic ovf;
    } div_side_t;

    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [QB-1:0]    low;
        logic [QB-1:0]    quot;
        logic [DEN_W-1:0] den;
        div_side_t        side;
    } div_stage_t;

    // Advance a restoring division by DIV_STEPS quotient bits.
    function automatic div_stage_t div_steps(div_stage_t s);
        div_stage_t       r;
        logic [DEN_W:0]   trial;
        r = s;
        for (int k = 0; k < DIV_STEPS; k++) begin
            trial = {r.rem, r.low[QB-1]};
            r.low = r.low << 1;
            if (trial >= {1'b0, r.den}) begin
                r.rem  = DEN_W'(trial - {1'b0, r.den});
                r.quot = {r.quot[QB-2:0], 1'b1};
            end else begin
                r.rem  = DEN_W'(trial);
                r.quot = {r.quot[QB-2:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/ds_twr_time_of_flight_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ds_twr_time_of_flight_core
// Asymmetric double-sided two-way ranging: time of flight and distance.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one item: the six timestamps of one exchange.
//   m_valid/m_ready/m_data return one item per input: flight time in ticks,
//   distance in mm, status and an out-of-range flag.
//   cfg_valid/cfg_index/cfg_data write distance_scale (index 0) or the
//   maximum range in mm (index 1); other indexes are dropped. cfg_ready is
//   always high. Write configuration only while no item is in flight.
// Throughput and pipeline:
//   One item per cycle while the output is not stalled. From acceptance to
//   m_valid an item passes eight arithmetic stages, the output register and a
//   21-stage divider that resolves two of the 42 quotient bits per stage. The
//   divider depth sets the latency.
// Reset:
//   aresetn (synchronous, low) empties the pipeline and loads the register
//   reset values (scale 307475, max distance 100000).
// Stall:
//   When m_valid is high and m_ready low the whole pipeline holds; s_ready
//   drops in the same cycle, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module ds_twr_time_of_flight_core
    import dstwr_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_item_t              s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_item_t                  m_data,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int HI_W  = STAMP_BITS - HALF_W;
    localparam int PP_W  = 2 * HALF_W;
    localparam int TH_W  = TOF_W / 2;
    localparam int SH_W  = SCALE_W / 2;
    localparam int DPP_W = TH_W + SH_W;
    localparam int DP_W  = TOF_W + SCALE_W;
    localparam int DQ_W  = DP_W - FRAC_W + 1;
    localparam int CMP_W = PROD_W + QB;

    // ---- configuration registers
    logic [SCALE_W-1:0] scale_reg;
    logic [MAXD_W-1:0]  maxd_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= SCALE_RESET;
            maxd_reg  <= MAXD_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_DISTANCE_SCALE:  scale_reg <= SCALE_W'(cfg_data);
                REG_MAX_DISTANCE_MM: maxd_reg  <= MAXD_W'(cfg_data);
                default: ;
            endcase
        end
    end

    // ---- global advance: move whenever the output slot is free or drains
    logic en;
    logic m_valid_reg;
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // ---- stage 1: intervals modulo 2^STAMP_BITS
    logic                  v1_reg;
    logic [STAMP_BITS-1:0] rnd1_reg, rep1_reg, rnd2_reg, rep2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            rnd1_reg <= s_data.resp_rx_time[STAMP_BITS-1:0] - s_data.poll_tx_time[STAMP_BITS-1:0];
            rep1_reg <= s_data.resp_tx_time[STAMP_BITS-1:0] - s_data.poll_rx_time[STAMP_BITS-1:0];
            rnd2_reg <= s_data.final_rx_time[STAMP_BITS-1:0] - s_data.resp_tx_time[STAMP_BITS-1:0];
            rep2_reg <= s_data.final_tx_time[STAMP_BITS-1:0] - s_data.resp_rx_time[STAMP_BITS-1:0];
        end
    end

    // ---- stage 2: denominator and half-width partial products
    logic              v2_reg;
    logic [DEN_W-1:0]  den2_reg;
    logic [PP_W-1:0]   pa_ll_reg, pa_lh_reg, pa_hl_reg, pa_hh_reg;
    logic [PP_W-1:0]   pb_ll_reg, pb_lh_reg, pb_hl_reg, pb_hh_reg;
    logic [HALF_W-1:0] a1_lo, a1_hi, a2_lo, a2_hi, b1_lo, b1_hi, b2_lo, b2_hi;

    always_comb begin
        a1_lo = rnd1_reg[HALF_W-1:0];
        a1_hi = HALF_W'(rnd1_reg[STAMP_BITS-1 -: HI_W]);
        a2_lo = rnd2_reg[HALF_W-1:0];
        a2_hi = HALF_W'(rnd2_reg[STAMP_BITS-1 -: HI_W]);
        b1_lo = rep1_reg[HALF_W-1:0];
        b1_hi = HALF_W'(rep1_reg[STAMP_BITS-1 -: HI_W]);
        b2_lo = rep2_reg[HALF_W-1:0];
        b2_hi = HALF_W'(rep2_reg[STAMP_BITS-1 -: HI_W]);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            den2_reg  <= DEN_W'(rnd1_reg) + DEN_W'(rnd2_reg) + DEN_W'(rep1_reg) + DEN_W'(rep2_reg);
            pa_ll_reg <= a1_lo * a2_lo;
            pa_lh_reg <= a1_lo * a2_hi;
            pa_hl_reg <= a1_hi * a2_lo;
            pa_hh_reg <= a1_hi * a2_hi;
            pb_ll_reg <= b1_lo * b2_lo;
            pb_lh_reg <= b1_lo * b2_hi;
            pb_hl_reg <= b1_hi * b2_lo;
            pb_hh_reg <= b1_hi * b2_hi;
        end
    end

    // ---- stage 3: assemble the two products
    logic              v3_reg;
    logic [DEN_W-1:0]  den3_reg;
    logic [PROD_W-1:0] pa3_reg, pb3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            den3_reg <= den2_reg;
            pa3_reg  <= PROD_W'(pa_ll_reg) + (PROD_W'(pa_lh_reg) << HALF_W)
                      + (PROD_W'(pa_hl_reg) << HALF_W) + (PROD_W'(pa_hh_reg) << (2 * HALF_W));
            pb3_reg  <= PROD_W'(pb_ll_reg) + (PROD_W'(pb_lh_reg) << HALF_W)
                      + (PROD_W'(pb_hl_reg) << HALF_W) + (PROD_W'(pb_hh_reg) << (2 * HALF_W));
        end
    end

    // ---- stage 4: sign and magnitude of the numerator
    logic              v4_reg;
    logic [DEN_W-1:0]  den4_reg;
    logic              neg4_reg;
    logic [PROD_W-1:0] mag4_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            den4_reg <= den3_reg;
            neg4_reg <= pa3_reg < pb3_reg;
            mag4_reg <= (pa3_reg < pb3_reg) ? pb3_reg - pa3_reg : pa3_reg - pb3_reg;
        end
    end

    // ---- stage 5: quotient overflow check and divider setup
    logic       v5_reg;
    div_stage_t div5_reg;
    div_stage_t div_in;
    logic [CMP_W-1:0] mag_ext;

    always_comb begin
        mag_ext       = CMP_W'(mag4_reg);
        div_in.rem    = DEN_W'(mag_ext >> QB);
        div_in.low    = QB'(mag_ext);
        div_in.quot   = '0;
        div_in.den    = den4_reg;
        div_in.side.zero_den = (den4_reg == '0);
        div_in.side.neg      = neg4_reg;
        div_in.side.ovf      = mag_ext >= (CMP_W'(den4_reg) << QB);
    end

    always_ff @(posedge aclk) begin
        if (en) div5_reg <= div_in;
    end

    // ---- divider
    logic       dv_valid;
    div_stage_t dv_stage;

    dstwr_divider u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v5_reg),
        .in_stage  (div5_reg),
        .out_valid (dv_valid),
        .out_stage (dv_stage)
    );

    // ---- stage 6: saturate the flight time
    logic             v6_reg;
    logic [TOF_W-1:0] tofmag6_reg;
    logic             neg6_reg, sat6_reg, zero6_reg;
    logic [TOF_W-1:0] tofmag_c;
    logic             sat_c;

    always_comb begin
        if (dv_stage.side.neg) begin
            sat_c    = dv_stage.side.ovf || (dv_stage.quot > TOF_MAG_NEG);
            tofmag_c = sat_c ? TOF_MAG_NEG : dv_stage.quot;
        end else begin
            sat_c    = dv_stage.side.ovf || (dv_stage.quot > TOF_MAX_POS);
            tofmag_c = sat_c ? TOF_MAX_POS : dv_stage.quot;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tofmag6_reg <= tofmag_c;
            neg6_reg    <= dv_stage.side.neg && (tofmag_c != '0);
            sat6_reg    <= sat_c;
            zero6_reg   <= dv_stage.side.zero_den;
        end
    end

    // ---- stage 7: distance partial products
    logic             v7_reg;
    logic [TOF_W-1:0] tofmag7_reg;
    logic             neg7_reg, sat7_reg, zero7_reg;
    logic [DPP_W-1:0] d_ll_reg, d_lh_reg, d_hl_reg, d_hh_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            tofmag7_reg <= tofmag6_reg;
            neg7_reg    <= neg6_reg;
            sat7_reg    <= sat6_reg;
            zero7_reg   <= zero6_reg;
            d_ll_reg    <= DPP_W'(tofmag6_reg[TH_W-1:0] * scale_reg[SH_W-1:0]);
            d_lh_reg    <= DPP_W'(tofmag6_reg[TH_W-1:0] * scale_reg[SCALE_W-1:SH_W]);
            d_hl_reg    <= DPP_W'(tofmag6_reg[TOF_W-1:TH_W] * scale_reg[SH_W-1:0]);
            d_hh_reg    <= DPP_W'(tofmag6_reg[TOF_W-1:TH_W] * scale_reg[SCALE_W-1:SH_W]);
        end
    end

    // ---- stage 8: assemble the distance product
    logic             v8_reg;
    logic [TOF_W-1:0] tofmag8_reg;
    logic             neg8_reg, sat8_reg, zero8_reg;
    logic [DP_W-1:0]  dp8_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            tofmag8_reg <= tofmag7_reg;
            neg8_reg    <= neg7_reg;
            sat8_reg    <= sat7_reg;
            zero8_reg   <= zero7_reg;
            dp8_reg     <= DP_W'(d_ll_reg) + (DP_W'(d_lh_reg) << SH_W)
                         + (DP_W'(d_hl_reg) << TH_W) + (DP_W'(d_hh_reg) << (TH_W + SH_W));
        end
    end

    // ---- stage 9: round, saturate, range check, output register
    logic [DQ_W-1:0]          dq;
    logic signed [DIST_W-1:0] dist_c;
    out_item_t                out_c;
    out_item_t                m_data_reg;

    always_comb begin
        dq = DQ_W'(dp8_reg >> FRAC_W);
        if (neg8_reg) begin
            // floor of a negative value: negate the ceiling of the magnitude
            dq = dq + DQ_W'(dp8_reg[FRAC_W-1:0] != '0);
            if (dq > DQ_W'(64'h8000_0000)) dist_c = {1'b1, {(DIST_W-1){1'b0}}};
            else                           dist_c = DIST_W'(-dq);
        end else begin
            if (dq > DQ_W'(64'h7FFF_FFFF)) dist_c = {1'b0, {(DIST_W-1){1'b1}}};
            else                           dist_c = DIST_W'(dq);
        end
        if (zero8_reg) begin
            out_c = '0;
            out_c.status = ST_ZERO_DEN;
        end else begin
            out_c.flight_time  = neg8_reg ? -tofmag8_reg : tofmag8_reg;
            out_c.range_mm     = dist_c;
            out_c.status       = sat8_reg ? ST_SATURATED : ST_OK;
            out_c.out_of_range = dist_c[DIST_W-1]
                              || (dist_c[DIST_W-2:0] > maxd_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) m_data_reg <= out_c;
    end

    // ---- valid bits travel with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            v6_reg      <= 1'b0;
            v7_reg      <= 1'b0;
            v8_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            v1_reg      <= s_valid;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            v4_reg      <= v3_reg;
            v5_reg      <= v4_reg;
            v6_reg      <= dv_valid;
            v7_reg      <= v6_reg;
            v8_reg      <= v7_reg;
            m_valid_reg <= v8_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ---- assertions
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.status == ST_OK || m_data.status == ST_ZERO_DEN
                  || m_data.status == ST_SATURATED))
        else $error("illegal status code");

    a_zero_den_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == ST_ZERO_DEN) |->
        (m_data.flight_time == '0 && m_data.range_mm == '0 && !m_data.out_of_range))
        else $error("zero denominator result not cleared");

    a_sat_pos_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == ST_SATURATED && !m_data.flight_time[TOF_W-1]) |->
        (m_data.flight_time == TOF_MAX_POS))
        else $error("positive saturation not clamped");

    a_negative_flagged: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.range_mm[DIST_W-1]) |-> m_data.out_of_range)
        else $error("negative distance not flagged");

endmodule
`default_nettype wire

@@ hw/rtl/dstwr_divider.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dstwr_divider
// Pipelined restoring divider, two quotient bits per stage.
// ----------------------------------------------------------------------------
module dstwr_divider
    import dstwr_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       en,
    input  wire logic       in_valid,
    input  wire div_stage_t in_stage,
    output logic            out_valid,
    output div_stage_t      out_stage
);

    div_stage_t stage_reg [DIV_STAGES];
    logic       valid_reg [DIV_STAGES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DIV_STAGES; i++) valid_reg[i] <= 1'b0;
        end else if (en) begin
            valid_reg[0] <= in_valid;
            for (int i = 1; i < DIV_STAGES; i++) valid_reg[i] <= valid_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            stage_reg[0] <= div_steps(in_stage);
            for (int i = 1; i < DIV_STAGES; i++) stage_reg[i] <= div_steps(stage_reg[i-1]);
        end
    end

    assign out_valid = valid_reg[DIV_STAGES-1];
    assign out_stage = stage_reg[DIV_STAGES-1];

endmodule
`default_nettype wire

@@ verif/tb_ds_twr_time_of_flight_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tb_ds_twr_time_of_flight_core
// Self-checking bench for the ranging core. It streams directed and random
// exchanges under random source gaps and sink stalls, predicts each result in
// an independent model, and compares the results in order, field by field.
// ----------------------------------------------------------------------------
module tb_ds_twr_time_of_flight_core;
    import dstwr_pkg::*;

    localparam int DRAIN_CYCLES = 40;   // pipeline is 30 deep; allow margin

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_item_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_item_t             m_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Bench copy of the two registers
    logic [SCALE_W-1:0] scale_q;
    logic [MAXD_W-1:0]  maxd_q;

    out_item_t range_expected[$];
    int        mismatch_count;
    bit        no_idle;         // when set, both sides run without gaps
    bit        hold_request;    // receiver takes one long stall

    ds_twr_time_of_flight_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Work out flight time and distance for one exchange
    function automatic out_item_t predict_range(in_item_t it);
        logic [STAMP_BITS-1:0] round1, reply1, round2, reply2;
        logic [DEN_W-1:0]      den;
        logic [79:0]           pa, pb, mag, quo;
        logic                  neg, sat;
        logic [TOF_W-1:0]      tof_mag;
        logic [81:0]           dprod;
        logic [63:0]           dmag;
        longint                range_val;
        out_item_t             r;
        round1 = it.resp_rx_time[STAMP_BITS-1:0] - it.poll_tx_time[STAMP_BITS-1:0];
        reply1 = it.resp_tx_time[STAMP_BITS-1:0] - it.poll_rx_time[STAMP_BITS-1:0];
        round2 = it.final_rx_time[STAMP_BITS-1:0] - it.resp_tx_time[STAMP_BITS-1:0];
        reply2 = it.final_tx_time[STAMP_BITS-1:0] - it.resp_rx_time[STAMP_BITS-1:0];
        den = DEN_W'(round1) + DEN_W'(round2) + DEN_W'(reply1) + DEN_W'(reply2);
        r = '0;
        if (den == '0) begin
            r.status = ST_ZERO_DEN;
            return r;
        end
        pa  = 80'(round1) * 80'(round2);
        pb  = 80'(reply1) * 80'(reply2);
        neg = (pa < pb);
        mag = neg ? pb - pa : pa - pb;
        quo = mag / 80'(den);
        sat = 1'b0;
        if (neg && quo > 80'(TOF_MAG_NEG)) begin
            tof_mag = TOF_MAG_NEG;
            sat     = 1'b1;
        end else if (!neg && quo > 80'(TOF_MAX_POS)) begin
            tof_mag = TOF_MAX_POS;
            sat     = 1'b1;
        end else begin
            tof_mag = quo[TOF_W-1:0];
        end
        if (tof_mag == '0) neg = 1'b0;
        r.flight_time = neg ? -tof_mag : tof_mag;
        // Scale, then floor the shift for negative flight times
        dprod = 82'(tof_mag) * 82'(scale_q);
        if (dprod[81:80] != 2'b00) begin
            dmag = 64'hFFFF_FFFF_FFFF;
        end else begin
            dmag = dprod[79:16];
            if (neg && dprod[15:0] != '0 && dmag < 64'hFFFF_FFFF_FFFF) dmag = dmag + 1;
        end
        if (neg) range_val = (dmag > 64'h8000_0000) ? -64'sd2147483648 : -longint'(dmag);
        else     range_val = (dmag > 64'h7FFF_FFFF) ? 64'sd2147483647 : longint'(dmag);
        r.range_mm     = range_val[31:0];
        r.status       = sat ? ST_SATURATED : ST_OK;
        r.out_of_range = (range_val < 0 || range_val > longint'(maxd_q));
        return r;
    endfunction

    function automatic logic [FIELD_W-1:0] rand_stamp();
        return FIELD_W'({$urandom, $urandom});
    endfunction

    // Well-formed exchange: tag and anchor clocks differ by a random offset
    function automatic in_item_t make_exchange();
        in_item_t              it;
        logic [FIELD_W-1:0]    offs, tof, reply_a, reply_b;
        offs    = rand_stamp();
        tof     = $urandom_range(0, 5000);
        reply_a = ($urandom_range(0, 3) == 0) ? rand_stamp() : $urandom_range(0, 1 << 24);
        reply_b = ($urandom_range(0, 3) == 0) ? rand_stamp() : $urandom_range(0, 1 << 24);
        it.poll_tx_time  = rand_stamp();
        it.poll_rx_time  = it.poll_tx_time + tof + offs;
        it.resp_tx_time  = it.poll_rx_time + reply_b;
        it.resp_rx_time  = it.resp_tx_time - offs + tof + $urandom_range(0, 3);
        it.final_tx_time = it.resp_rx_time + reply_a;
        it.final_rx_time = it.final_tx_time + offs + tof + $urandom_range(0, 3);
        return it;
    endfunction

    function automatic in_item_t make_noise();
        in_item_t it;
        it = {rand_stamp(), rand_stamp(), rand_stamp(),
              rand_stamp(), rand_stamp(), rand_stamp()};
        return it;
    endfunction

    // Offer one item after a random gap; hold valid until accepted
    task automatic send_exchange(input in_item_t it);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_mix(input int count, input int noise_pct);
        for (int i = 0; i < count; i++) begin
            if (i % 150 == 0) no_idle = ($urandom_range(0, 2) == 0);
            if ($urandom_range(0, 99) < noise_pct) send_exchange(make_noise());
            else send_exchange(make_exchange());
        end
        no_idle = 1'b0;
    endtask

    // Let the pipeline empty before touching registers
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (range_expected.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_DISTANCE_SCALE)       scale_q = value[SCALE_W-1:0];
        else if (idx == REG_MAX_DISTANCE_MM) maxd_q  = value[MAXD_W-1:0];
    endtask

    // Extremes, zero denominator, wrap and sign cases at reset settings
    task automatic test_directed();
        in_item_t it;
        send_exchange('0);                               // zero denominator
        send_exchange('1);                               // all equal: zero again
        it = '0;
        it.resp_rx_time = '1; it.final_rx_time = '1;    // big rounds
        it.resp_tx_time = 40'd5;
        send_exchange(it);
        it = '0;
        it.resp_tx_time = '1; it.final_tx_time = '1;    // big replies: negative
        send_exchange(it);
        it = '0;
        it.poll_tx_time = '1; it.poll_rx_time = '1;     // wrap through zero
        it.resp_tx_time = 40'd100; it.resp_rx_time = 40'd300;
        it.final_tx_time = 40'd500; it.final_rx_time = 40'd700;
        send_exchange(it);
        it = '0;
        it.resp_rx_time = 40'd1; it.final_rx_time = 40'd1;  // tiny positive
        send_exchange(it);
        it = '0;
        it.resp_tx_time = 40'd1; it.final_tx_time = 40'd3;  // tiny negative
        send_exchange(it);
        for (int i = 0; i < 6; i++) send_exchange(make_exchange());
        for (int i = 0; i < 4; i++) send_exchange(make_noise());
    endtask

    // Walk the registers through extremes and typical values
    task automatic test_register_settings();
        drain();
        write_reg(REG_DISTANCE_SCALE, '1);               // distance saturates
        write_reg(REG_MAX_DISTANCE_MM, '0);
        send_mix(150, 30);
        drain();
        write_reg(REG_DISTANCE_SCALE, '0);
        write_reg(REG_MAX_DISTANCE_MM, 40'h7FFF_FFFF);
        send_mix(150, 30);
        drain();
        write_reg(8'd7, 40'h12_3456_7890);               // unknown index: dropped
        write_reg(REG_MAX_DISTANCE_MM, '1);              // upper bits dropped
        write_reg(REG_DISTANCE_SCALE, 40'd1 << 16);
        send_mix(150, 30);
        drain();
        write_reg(REG_DISTANCE_SCALE, rand_stamp());
        write_reg(REG_MAX_DISTANCE_MM, $urandom);
        send_mix(150, 30);
        drain();
        write_reg(REG_DISTANCE_SCALE, 40'd307475);
        write_reg(REG_MAX_DISTANCE_MM, 40'd100000);
    endtask

    task automatic test_random_exchanges();
        send_mix(1100, 20);
    endtask

    // Stall the sink for a long stretch while the source keeps offering
    task automatic test_backpressure();
        hold_request = 1'b1;
        no_idle      = 1'b1;
        for (int i = 0; i < 150; i++) send_exchange(make_exchange());
        no_idle = 1'b0;
    endtask

    // Sink: random stall before each item, with one long hold on request
    initial begin
        int wait_cycles;
        m_ready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            wait_cycles = no_idle ? 0 : $urandom_range(0, 13);
            if (hold_request) begin
                wait_cycles  = 300;
                hold_request = 1'b0;
            end
            if (wait_cycles > 0) begin
                m_ready <= 1'b0;
                repeat (wait_cycles) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Predict on input acceptance, compare on output acceptance
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && s_valid && s_ready) range_expected.push_back(predict_range(s_data));
        if (aresetn && m_valid && m_ready) begin
            if (range_expected.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("unexpected item: %p", m_data);
            end else begin
                want = range_expected.pop_front();
                if (m_data.flight_time !== want.flight_time
                        || m_data.range_mm !== want.range_mm
                        || m_data.status !== want.status
                        || m_data.out_of_range !== want.out_of_range) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch: expected tof %0d dist %0d st %0d oor %0d,",
                                  " got tof %0d dist %0d st %0d oor %0d"},
                                 want.flight_time, want.range_mm, want.status,
                                 want.out_of_range, m_data.flight_time,
                                 m_data.range_mm, m_data.status, m_data.out_of_range);
                end
            end
        end
    end

    initial begin
        #50_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        mismatch_count = 0;
        no_idle        = 1'b0;
        hold_request   = 1'b0;
        scale_q        = SCALE_RESET;
        maxd_q         = MAXD_RESET;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random_exchanges();
        test_backpressure();
        test_register_settings();
        send_mix(100, 20);
        drain();

        if (range_expected.size() != 0) mismatch_count++;
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
`default_nettype wire

@@ sim.f @@
hw/rtl/dstwr_pkg.sv
hw/rtl/dstwr_divider.sv
hw/rtl/ds_twr_time_of_flight_core.sv
verif/tb_ds_twr_time_of_flight_core.sv
